>>> design/sliding_window_median_core_assert.svh
// Assertion macros shared by the running median checker.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define SWM_ASSERT_NOW(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error("running median check failed");

// Next-cycle implication, clocked on clock, off during reset.
`define SWM_ASSERT_NEXT(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error("running median check failed");

`endif

>>> design/swm_pkg.sv
// Shared types and constants of the running median block.
`timescale 1ns / 1ps

package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int OUT_W    = 33;
   localparam int CSR_W    = 6;
   localparam logic [CSR_W-1:0] WINDOW_RESET = CSR_W'(3);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DELETE,
      ST_INSERT,
      ST_EMIT
   } swm_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic cfg_write;
      logic ring_read;
      logic delete_old;
      logic insert_new;
      logic emit;
   } swm_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic window_full;
      logic out_free;
   } swm_status_type;

endpackage

>>> design/swm_ctrl.sv
// Sequencing state machine of the running median block.
`timescale 1ns / 1ps

module swm_ctrl
   import swm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  swm_status_type status,
   output swm_cmd_type    cmd
);

   swm_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            // config only taken when no word is offered
            csr_ready = !req_valid;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end else if (csr_valid) begin
               cmd.cfg_write = 1'b1;
            end
         end
         ST_PREP: begin
            cmd.ring_read = 1'b1;
            state_in = status.window_full ? ST_DELETE : ST_INSERT;
         end
         ST_DELETE: begin
            cmd.delete_old = 1'b1;
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert_new = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.window_full) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/swm_datapath.sv
// Sample ring, sorted cell chain, counters and result register.
`timescale 1ns / 1ps

module swm_datapath
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  swm_cmd_type                cmd,
   output swm_status_type             status,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_restart,
   input  logic        [CSR_W-1:0]    csr_window_size,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_W-1:0]    rsp_median_doubled
);

   localparam int KW = $clog2(WINDOW_MAX + 1);
   localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   // Clamp the register value to 1..WINDOW_MAX
   function automatic logic [KW-1:0] eff_size(input logic [CSR_W-1:0] ws);
      logic [KW-1:0] k;
      if (ws == '0) begin
         k = KW'(1);
      end else if (32'(ws) > 32'(WINDOW_MAX)) begin
         k = KW'(WINDOW_MAX);
      end else begin
         k = KW'(ws);
      end
      return k;
   endfunction

   logic        [KW-1:0]       k_ff, k_in;
   logic        [KW-1:0]       fill_ff, fill_in;
   logic        [PW-1:0]       ptr_ff, ptr_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] oldest_ff;
   logic signed [SAMPLE_W-1:0] cell_ff [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] cell_in [WINDOW_MAX];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]    median_ff;
   logic        [KW-1:0]       ins_count;
   logic        [KW-1:0]       k_minus1;
   logic        [KW-1:0]       lo_idx, hi_idx;
   logic        [KW:0]         ptr_next;
   logic signed [SAMPLE_W-1:0] lo_val, hi_val;
   logic                       window_full;

   assign window_full = (fill_ff == k_ff);
   assign k_minus1    = k_ff - KW'(1);
   assign ins_count   = window_full ? k_minus1 : fill_ff;
   assign lo_idx      = k_minus1 >> 1;
   assign hi_idx      = k_ff >> 1;
   assign ptr_next    = (KW+1)'(ptr_ff) + (KW+1)'(1);

   assign status.window_full = window_full;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   // Window size, fill count and ring pointer
   always_comb begin
      k_in    = k_ff;
      fill_in = fill_ff;
      ptr_in  = ptr_ff;
      if (cmd.cfg_write) begin
         k_in    = eff_size(csr_window_size);
         fill_in = '0;
         ptr_in  = '0;
      end else if (cmd.load && req_restart) begin
         fill_in = '0;
         ptr_in  = '0;
      end else if (cmd.insert_new) begin
         if (!window_full) begin
            fill_in = fill_ff + KW'(1);
         end
         ptr_in = (ptr_next >= (KW+1)'(k_ff)) ? '0 : ptr_next[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= eff_size(WINDOW_RESET);
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         k_ff    <= k_in;
         fill_ff <= fill_in;
         ptr_ff  <= ptr_in;
      end
   end

   // Incoming word capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
      end
   end

   // Sample ring in arrival order, registered read of the oldest
   always_ff @(posedge clock) begin
      if (cmd.insert_new) begin
         ring_mem[ptr_ff] <= sample_ff;
      end
      if (cmd.ring_read) begin
         oldest_ff <= ring_mem[ptr_ff];
      end
   end

   // Sorted cell chain: drop oldest by shifting left, insert by shifting right
   always_comb begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (cmd.delete_old) begin
         for (int i = 0; i < WINDOW_MAX - 1; i++) begin
            if ((KW'(i) < k_minus1) && (cell_ff[i] >= oldest_ff)) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
      end else if (cmd.insert_new) begin
         for (int i = 0; i < WINDOW_MAX; i++) begin
            if ((KW'(i) < ins_count) && (cell_ff[i] <= sample_ff)) begin
               cell_in[i] = cell_ff[i];
            end else if (KW'(i) <= ins_count) begin
               if ((i > 0) && (cell_ff[(i > 0) ? i - 1 : 0] > sample_ff)) begin
                  cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
               end else begin
                  cell_in[i] = sample_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // Middle pair selection by one-hot compare
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (KW'(i) == lo_idx) begin
            lo_val = lo_val | cell_ff[i];
         end
         if (KW'(i) == hi_idx) begin
            hi_val = hi_val | cell_ff[i];
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         median_ff <= {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;

endmodule

>>> design/sliding_window_median_core.sv
// Top level of the running median filter.
`timescale 1ns / 1ps

// Running median over the last window_size signed 32-bit samples (1..WINDOW_MAX,
// 0 acts as 1, larger values as WINDOW_MAX). Each result is twice the median,
// or the sum of the two middle samples for an even window, as a 33-bit signed
// word. No result comes until window_size samples have arrived since a restart
// word or a csr write (either one empties the window). One word is in work at a
// time: a prep, an insert and a result step per word, with a delete step before
// the insert once the window is full, set by the single ring read port and the
// sorted cell chain that first drops the oldest sample and then inserts the new
// one. A result waiting on rsp_stall holds the next word only once that word
// reaches its result step. The csr write is taken only while idle with no word
// offered. No clearing pass follows reset.
module sliding_window_median_core
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_W-1:0]    rsp_median_doubled,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic        [CSR_W-1:0]    csr_window_size
);

   swm_cmd_type    cmd;
   swm_status_type status;

   // Controller
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   swm_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sample         (req_sample),
      .req_restart        (req_restart),
      .csr_window_size    (csr_window_size),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_median_doubled (rsp_median_doubled)
   );

endmodule

>>> design/swm_checker.sv
// Port-level checker of the running median filter and its bind.
`timescale 1ns / 1ps

`include "sliding_window_median_core_assert.svh"

module swm_checker
   import swm_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [OUT_W-1:0]    rsp_median_doubled,
   input logic                       csr_valid,
   input logic                       csr_ready
);

   // A stalled result word holds
   `SWM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_median_doubled))

   // One word in work at a time
   `SWM_ASSERT_NEXT(a_one_in_work, req_valid && !req_stall, req_stall)

   // Csr write and word accept never share an edge
   `SWM_ASSERT_NOW(a_csr_excl, csr_valid && csr_ready, !(req_valid && !req_stall))

   // A new result only follows work in progress
   `SWM_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(req_stall))

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (.*);
